### hw/rtl/lcs_pkg.sv
// Package for the letter counting sort block: sizes, letter bases, request
// structs, cell status struct and the controller state type.
// No dependencies; used by every module of the block.
package lcs_pkg;

    localparam int ALPHA_SIZE = 26;
    localparam int MAX_LEN    = 64;
    localparam int CNT_W      = $clog2(MAX_LEN + 1);
    localparam int IDX_W      = $clog2(ALPHA_SIZE);

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_req;

    typedef struct packed {
        logic [7:0] letter_code;
        logic       end_of_run;
        logic       empty_result;
        logic       dropped_seen;
    } t_out_req;

    // Status one cell reports for the current emission step.
    typedef struct packed {
        logic emit;
        logic pass;
    } t_cell_stat;

    typedef enum logic [1:0] {
        ST_COUNT,
        ST_EMIT,
        ST_EMPTY
    } t_state;

endpackage

### hw/rtl/lcs_cell.sv
// One cell of the counting chain: the count of a single letter and the
// emission token that walks from cell to cell. Depends on lcs_pkg.
module lcs_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_inc,
    input  logic                  i_step,
    input  logic                  i_tok_in,
    input  logic                  i_clear,
    output lcs_pkg::t_cell_stat   o_stat
);

    logic [lcs_pkg::CNT_W-1:0] r_cnt;
    logic [lcs_pkg::CNT_W-1:0] n_cnt;
    logic                      r_tok;
    logic                      n_tok;

    always_comb begin
        o_stat.emit = r_tok && i_step && (r_cnt != '0);
        // The token moves on once the last copy of this letter goes out,
        // or at once if the letter was never counted.
        o_stat.pass = r_tok && i_step && (r_cnt <= lcs_pkg::CNT_W'(1));

        n_cnt = r_cnt;
        if (i_inc) begin
            n_cnt = r_cnt + lcs_pkg::CNT_W'(1);
        end else if (o_stat.emit) begin
            n_cnt = r_cnt - lcs_pkg::CNT_W'(1);
        end

        n_tok = r_tok;
        if (i_clear) begin
            n_tok = 1'b0;
        end else if (i_tok_in) begin
            n_tok = 1'b1;
        end else if (o_stat.pass) begin
            n_tok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_tok <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_tok <= n_tok;
        end
    end

endmodule

### hw/rtl/letter_counting_sort.sv
// While counting, one character request is taken every cycle. After the
// request that carries last_char, the sorted letters leave one per cycle
// while the output is not stalled, except where the token steps over a
// letter that was never counted. An empty string gives its single result.
// Reset (synchronous, active low) clears all counts, the mode register and flags.
module letter_counting_sort (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lcs_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lcs_pkg::t_out_req o_out_req,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data
);

    // Controller state, mode register and per-string bookkeeping.
    lcs_pkg::t_state           r_state;
    lcs_pkg::t_state           n_state;
    logic                      r_upper;
    logic                      r_base_upper;
    logic                      r_drop;
    logic                      n_drop;
    logic [lcs_pkg::CNT_W-1:0] r_total;
    logic [lcs_pkg::CNT_W-1:0] n_total;
    logic [lcs_pkg::IDX_W-1:0] r_letter;
    logic [lcs_pkg::IDX_W-1:0] n_letter;

    // Output register.
    logic                      r_out_valid;
    logic                      n_out_valid;
    lcs_pkg::t_out_req         r_out_req;
    lcs_pkg::t_out_req         n_out_req;

    // Classification of the incoming character.
    logic                      in_accept;
    logic [7:0]                in_base;
    logic [7:0]                in_diff;
    logic                      in_alpha;
    logic                      counted;
    logic [lcs_pkg::CNT_W-1:0] total_after;

    // Chain signals.
    logic [lcs_pkg::ALPHA_SIZE-1:0] cell_inc;
    logic [lcs_pkg::ALPHA_SIZE-1:0] cell_tok_in;
    logic [lcs_pkg::ALPHA_SIZE-1:0] cell_emit;
    logic [lcs_pkg::ALPHA_SIZE-1:0] cell_pass;
    lcs_pkg::t_cell_stat            cell_stat [lcs_pkg::ALPHA_SIZE];
    logic                           load_ok;
    logic                           step;
    logic                           start;
    logic                           done;
    logic                           any_emit;
    logic [7:0]                     out_base;

    // The configuration register can always be written; a new mode applies
    // from the next character on, and emission keeps the base letter that
    // was latched with the last character.
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != lcs_pkg::ST_COUNT);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    assign in_accept = i_in_valid && !o_in_stall;

    // A character is a letter of the selected alphabet when it lies in the
    // 26 codes starting at the base letter.
    assign in_base  = r_upper ? lcs_pkg::CHAR_UPPER_A : lcs_pkg::CHAR_LOWER_A;
    assign in_diff  = i_in_req.char_code - in_base;
    assign in_alpha = (i_in_req.char_code >= in_base)
                      && (in_diff < 8'(lcs_pkg::ALPHA_SIZE));
    // Letters past the length limit are dropped like non-letters.
    assign counted  = in_accept && in_alpha
                      && (r_total < lcs_pkg::CNT_W'(lcs_pkg::MAX_LEN));
    assign total_after = r_total + lcs_pkg::CNT_W'(counted);

    // The output register may take a new result when it is empty or its
    // current result is being taken this cycle.
    assign load_ok = !r_out_valid || !i_out_stall;
    assign step    = load_ok && (r_state == lcs_pkg::ST_EMIT);
    assign start   = in_accept && i_in_req.last_char && (total_after != '0);

    always_comb begin
        for (int k = 0; k < lcs_pkg::ALPHA_SIZE; k++) begin
            cell_inc[k]  = counted && (in_diff[lcs_pkg::IDX_W-1:0] == lcs_pkg::IDX_W'(k));
            cell_emit[k] = cell_stat[k].emit;
            cell_pass[k] = cell_stat[k].pass;
        end
    end

    // The token enters at the first cell and each cell hands it on to the next.
    assign cell_tok_in = {cell_pass[lcs_pkg::ALPHA_SIZE-2:0], start};
    assign any_emit    = |cell_emit;
    // The last letter of the run ends emission and retires the token.
    assign done        = any_emit && (r_total == lcs_pkg::CNT_W'(1));

    genvar g;
    generate
        for (g = 0; g < lcs_pkg::ALPHA_SIZE; g++) begin : g_cell
            lcs_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_inc    (cell_inc[g]),
                .i_step   (step),
                .i_tok_in (cell_tok_in[g]),
                .i_clear  (done),
                .o_stat   (cell_stat[g])
            );
        end
    endgenerate

    assign out_base = r_base_upper ? lcs_pkg::CHAR_UPPER_A : lcs_pkg::CHAR_LOWER_A;

    always_comb begin
        n_state     = r_state;
        n_drop      = r_drop;
        n_total     = r_total;
        n_letter    = r_letter;
        n_out_valid = r_out_valid;
        n_out_req   = r_out_req;

        if (load_ok) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lcs_pkg::ST_COUNT: begin
                n_total = total_after;
                if (in_accept && !counted) begin
                    n_drop = 1'b1;
                end
                if (in_accept && i_in_req.last_char) begin
                    n_letter = '0;
                    n_state  = (total_after == '0) ? lcs_pkg::ST_EMPTY
                                                   : lcs_pkg::ST_EMIT;
                end
            end
            lcs_pkg::ST_EMIT: begin
                if (any_emit) begin
                    n_out_valid              = 1'b1;
                    n_out_req.letter_code    = out_base + 8'(r_letter);
                    n_out_req.end_of_run     = done;
                    n_out_req.empty_result   = 1'b0;
                    n_out_req.dropped_seen   = r_drop;
                    n_total                  = r_total - lcs_pkg::CNT_W'(1);
                end
                if (|cell_pass) begin
                    n_letter = r_letter + lcs_pkg::IDX_W'(1);
                end
                if (done) begin
                    n_letter = '0;
                    n_drop   = 1'b0;
                    n_state  = lcs_pkg::ST_COUNT;
                end
            end
            lcs_pkg::ST_EMPTY: begin
                if (load_ok) begin
                    n_out_valid              = 1'b1;
                    n_out_req.letter_code    = '0;
                    n_out_req.end_of_run     = 1'b1;
                    n_out_req.empty_result   = 1'b1;
                    n_out_req.dropped_seen   = r_drop;
                    n_drop                   = 1'b0;
                    n_state                  = lcs_pkg::ST_COUNT;
                end
            end
            default: begin
                n_state = lcs_pkg::ST_COUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lcs_pkg::ST_COUNT;
            r_upper      <= 1'b0;
            r_base_upper <= 1'b0;
            r_drop       <= 1'b0;
            r_total      <= '0;
            r_letter     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_drop      <= n_drop;
            r_total     <= n_total;
            r_letter    <= n_letter;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_upper <= i_cfg_data;
            end
            // Emission uses the mode in force at the last character.
            if (in_accept && i_in_req.last_char) begin
                r_base_upper <= r_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_req <= n_out_req;
    end

endmodule

### hw/rtl/lcs_checker.sv
// Port-level checker for letter_counting_sort, bound to the top level.
// Depends on lcs_pkg and the top-level port list.
module lcs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input lcs_pkg::t_in_req  i_in_req,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input lcs_pkg::t_out_req o_out_req
);

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_req))
        else $error("stalled result changed or vanished");

    // The empty result is a lone end marker with no letter.
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.empty_result |->
            o_out_req.end_of_run && (o_out_req.letter_code == 8'h00))
        else $error("malformed empty result");

    // Every non-empty result is a letter of one of the two alphabets.
    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_req.empty_result |->
            ((o_out_req.letter_code >= lcs_pkg::CHAR_LOWER_A)
             && (o_out_req.letter_code < lcs_pkg::CHAR_LOWER_A + 8'd26))
            || ((o_out_req.letter_code >= lcs_pkg::CHAR_UPPER_A)
             && (o_out_req.letter_code < lcs_pkg::CHAR_UPPER_A + 8'd26)))
        else $error("result letter out of range");

    // After the last character of a string the input is held off while
    // the sorted run is produced.
    a_stall_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_req.last_char |=> o_in_stall)
        else $error("input taken during emission");

endmodule

bind letter_counting_sort lcs_checker u_lcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_req   (o_out_req)
);

### verif/tb_letter_counting_sort.sv
// Self-checking testbench for letter_counting_sort: directed table plus random strings.
// The predictor and the expected-letter queue are built here.
// Depends on lcs_pkg and the letter_counting_sort RTL only.
module tb_letter_counting_sort;

    import lcs_pkg::*;

    localparam int IDLE_PCT      = 6;
    localparam int SETTLE_CYCLES = 40;      // settle time that drain() waits after the expected queue empties
    localparam int LIMIT_CYCLES  = 400000;
    localparam int DIR_ROWS      = 25;
    localparam int PHASE_ITEMS   = 50;

    // Mode write that a directed row asks for before its first request.
    typedef enum logic [1:0] {
        WR_NONE,
        WR_LOWER,
        WR_UPPER
    } t_mode_wr;

    // One row of the directed table. The row is sent reps times; where typed is
    // set, the single sorted result of that request is the one typed in res.
    typedef struct packed {
        t_mode_wr   mode_wr;
        logic [7:0] ch;
        logic       last;
        logic [6:0] reps;
        logic       typed;
        t_out_req   res;
    } t_dir_row;

    localparam t_out_req NO_RES     = '0;
    localparam t_out_req EMPTY_DROP = '{8'h00, 1'b1, 1'b1, 1'b1};

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_stall;
    t_in_req  i_in_req    = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_out_req o_out_req;
    logic     i_cfg_valid = 1'b0;
    logic     o_cfg_ready;
    logic     i_cfg_data  = 1'b0;

    // Typed expectation that travels alongside the character request.
    logic     req_is_typed  = 1'b0;
    t_out_req req_typed_res = '0;

    // Predictor state: one tally per letter, number of kept letters, drop flag
    // and the mode register as the block should hold it.
    logic [6:0] tally [ALPHA_SIZE];
    logic [6:0] kept;
    logic       lost;
    logic       upper_mode;

    t_out_req   sorted_q [$];
    t_out_req   want;
    t_dir_row   dir_rows [DIR_ROWS];
    int         err_count   = 0;
    int         cycle_count = 0;
    int         idle_pct    = IDLE_PCT;
    logic       mode_set    = 1'b0;    // mode the stimulus last wrote

    letter_counting_sort dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // A hard stop in case the block hangs on a handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb_letter_counting_sort: errors");
            $finish;
        end
    end

    function automatic void clear_tally();
        for (int k = 0; k < ALPHA_SIZE; k++) begin
            tally[k] = '0;
        end
        kept = '0;
        lost = 1'b0;
    endfunction

    // Counts one accepted character; on the last of a string it queues the typed
    // result if given, else the empty result or the letters in alphabetical order.
    // Each character is classified with the mode in force when it is accepted;
    // the emitted letters take their base from the mode in force at the last one.
    task automatic predict_char(input t_in_req r, input logic typed, input t_out_req typed_res);
        logic [7:0] base;
        int         off;
        int         n;
        int         k;
        int         c;
        t_out_req   res;
        base = upper_mode ? CHAR_UPPER_A : CHAR_LOWER_A;
        off  = int'(r.char_code) - int'(base);
        if (off >= 0 && off < ALPHA_SIZE && kept < MAX_LEN) begin
            tally[off] = tally[off] + 7'd1;
            kept       = kept + 7'd1;
        end else begin
            // Either not a letter of the selected case, or the string is full.
            lost = 1'b1;
        end
        if (r.last_char) begin
            if (typed) begin
                sorted_q.push_back(typed_res);
            end else if (kept == 0) begin
                sorted_q.push_back({8'h00, 1'b1, 1'b1, lost});
            end else begin
                n = 0;
                for (k = 0; k < ALPHA_SIZE; k++) begin
                    for (c = 0; c < int'(tally[k]); c++) begin
                        n++;
                        res.letter_code  = base + 8'(k);
                        res.end_of_run   = (n == int'(kept));
                        res.empty_result = 1'b0;
                        res.dropped_seen = lost;
                        sorted_q.push_back(res);
                    end
                end
            end
            clear_tally();
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %h actual %h", $time, what, exp_v, act_v);
            err_count++;
        end
    endtask

    // Boundary monitor. Every sample is taken at the clock edge, before any of
    // this edge's nonblocking updates land, so the order of processes within
    // the step does not matter. The output stall is redrawn here as well.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_tally();
            upper_mode = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                upper_mode = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                predict_char(i_in_req, req_is_typed, req_typed_res);
            end
            if (o_out_valid && !i_out_stall) begin
                if (sorted_q.size() == 0) begin
                    $display("%0t: result %h arrived with nothing expected", $time, o_out_req);
                    err_count++;
                end else begin
                    want = sorted_q.pop_front();
                    check_field("letter_code", want.letter_code, o_out_req.letter_code);
                    check_field("end_of_run", 8'(want.end_of_run), 8'(o_out_req.end_of_run));
                    check_field("empty_result", 8'(want.empty_result),
                                8'(o_out_req.empty_result));
                    check_field("dropped_seen", 8'(want.dropped_seen),
                                8'(o_out_req.dropped_seen));
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < idle_pct);
    end

    // Offers one character request, with random idle cycles in front of it,
    // and returns in the step where it was taken.
    task automatic push_char(input t_in_req r, input logic typed, input t_out_req typed_res);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_req      <= r;
        req_is_typed  <= typed;
        req_typed_res <= typed_res;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    // Holds the sender off until every expected letter is out, then waits out
    // the settle time before it returns. The first edge lets the monitor queue
    // the results of a request taken just now.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sorted_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mode_set = m;
    endtask

    // One random string: mostly letters of the selected case, some of the
    // other case and some arbitrary bytes, closed by last_char.
    task automatic send_string(input int len);
        t_in_req    r;
        int         pick;
        int         i;
        logic [7:0] own_base;
        logic [7:0] other_base;
        own_base   = mode_set ? CHAR_UPPER_A : CHAR_LOWER_A;
        other_base = mode_set ? CHAR_LOWER_A : CHAR_UPPER_A;
        for (i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                r.char_code = own_base + 8'($urandom_range(ALPHA_SIZE - 1));
            end else if (pick < 90) begin
                r.char_code = other_base + 8'($urandom_range(ALPHA_SIZE - 1));
            end else begin
                r.char_code = 8'($urandom_range(255));
            end
            r.last_char = (i == len - 1);
            push_char(r, 1'b0, NO_RES);
        end
    endtask

    initial begin
        t_dir_row row;
        t_in_req  r;
        int       i;
        int       j;
        int       phase;
        int       sent;
        int       len;

        // Empty strings, single extreme letters, characters just outside the
        // alphabet, a string that overflows, and a mode change mid-string.
        dir_rows[0]  = '{WR_LOWER, 8'h00, 1'b1, 7'd1, 1'b1, EMPTY_DROP};
        dir_rows[1]  = '{WR_NONE, 8'h61, 1'b1, 7'd1, 1'b1, '{8'h61, 1'b1, 1'b0, 1'b0}};
        dir_rows[2]  = '{WR_NONE, 8'h7A, 1'b1, 7'd1, 1'b1, '{8'h7A, 1'b1, 1'b0, 1'b0}};
        dir_rows[3]  = '{WR_NONE, 8'hFF, 1'b1, 7'd1, 1'b1, EMPTY_DROP};
        dir_rows[4]  = '{WR_NONE, 8'h60, 1'b0, 7'd1, 1'b0, NO_RES};
        dir_rows[5]  = '{WR_NONE, 8'h7B, 1'b0, 7'd1, 1'b0, NO_RES};
        dir_rows[6]  = '{WR_NONE, 8'h41, 1'b0, 7'd1, 1'b0, NO_RES};
        dir_rows[7]  = '{WR_NONE, 8'h6D, 1'b0, 7'd1, 1'b0, NO_RES};
        dir_rows[8]  = '{WR_NONE, 8'h63, 1'b0, 7'd1, 1'b0, NO_RES};
        dir_rows[9]  = '{WR_NONE, 8'h6D, 1'b0, 7'd1, 1'b0, NO_RES};
        dir_rows[10] = '{WR_NONE, 8'h61, 1'b1, 7'd1, 1'b0, NO_RES};
        // Fill the string to its limit, then one more letter that is dropped.
        dir_rows[11] = '{WR_NONE, 8'h71, 1'b0, 7'd64, 1'b0, NO_RES};
        dir_rows[12] = '{WR_NONE, 8'h62, 1'b1, 7'd1, 1'b0, NO_RES};
        dir_rows[13] = '{WR_NONE, 8'h62, 1'b0, 7'd3, 1'b0, NO_RES};
        dir_rows[14] = '{WR_NONE, 8'h61, 1'b1, 7'd1, 1'b0, NO_RES};
        // Lower-case x counted, then the mode flips to upper case mid-string.
        dir_rows[15] = '{WR_NONE, 8'h78, 1'b0, 7'd1, 1'b0, NO_RES};
        dir_rows[16] = '{WR_UPPER, 8'h58, 1'b0, 7'd1, 1'b0, NO_RES};
        dir_rows[17] = '{WR_NONE, 8'h78, 1'b0, 7'd1, 1'b0, NO_RES};
        dir_rows[18] = '{WR_NONE, 8'h42, 1'b1, 7'd1, 1'b0, NO_RES};
        dir_rows[19] = '{WR_NONE, 8'h41, 1'b1, 7'd1, 1'b1, '{8'h41, 1'b1, 1'b0, 1'b0}};
        dir_rows[20] = '{WR_NONE, 8'h5A, 1'b1, 7'd1, 1'b1, '{8'h5A, 1'b1, 1'b0, 1'b0}};
        dir_rows[21] = '{WR_NONE, 8'h40, 1'b0, 7'd1, 1'b0, NO_RES};
        dir_rows[22] = '{WR_NONE, 8'h5B, 1'b1, 7'd1, 1'b1, EMPTY_DROP};
        dir_rows[23] = '{WR_NONE, 8'h61, 1'b1, 7'd1, 1'b1, EMPTY_DROP};
        dir_rows[24] = '{WR_LOWER, 8'h6B, 1'b1, 7'd1, 1'b1, '{8'h6B, 1'b1, 1'b0, 1'b0}};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < DIR_ROWS; i++) begin
            row = dir_rows[i];
            if (row.mode_wr == WR_LOWER) begin
                write_mode(1'b0);
            end else if (row.mode_wr == WR_UPPER) begin
                write_mode(1'b1);
            end
            r.char_code = row.ch;
            r.last_char = row.last;
            for (j = 0; j < int'(row.reps); j++) begin
                push_char(r, row.typed, row.res);
            end
        end

        // Random phases alternate the case. The third phase runs without any
        // idle or stall cycles on either side.
        for (phase = 0; phase < 4; phase++) begin
            write_mode(!mode_set);
            idle_pct = (phase == 2) ? 0 : IDLE_PCT;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // Now and then a long string near the length limit, which may overflow.
                if ($urandom_range(11) == 0) begin
                    len = $urandom_range(72, 60);
                end else begin
                    len = $urandom_range(12, 1);
                end
                send_string(len);
                sent += len;
            end
        end

        drain();
        if (err_count == 0) begin
            $display("tb_letter_counting_sort: clean");
        end else begin
            $display("tb_letter_counting_sort: errors");
        end
        $finish;
    end

endmodule
